// ----- design/pvmm_pkg.sv -----
// ----------------------------------------------------------------------------
// pvmm_pkg
// Types and constants shared by the video memory map and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pvmm_pkg;

  // bus address width and region boundaries
  localparam int unsigned ADDR_W       = 14;
  localparam logic [13:0] NT_BASE      = 14'h2000;
  localparam logic [13:0] PAL_BASE     = 14'h3F00;
  localparam int unsigned PAL_AW       = 5;

  // access kind
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // target region of an access
  typedef enum logic [1:0] {
    REGION_CART      = 2'd0,
    REGION_PATTERN   = 2'd1,
    REGION_NAMETABLE = 2'd2,
    REGION_PALETTE   = 2'd3
  } region_t;

  // name table mirroring mode
  typedef enum logic [1:0] {
    MIRROR_HORIZ  = 2'd0,
    MIRROR_VERT   = 2'd1,
    MIRROR_SINGLE_LO = 2'd2,
    MIRROR_SINGLE_HI = 2'd3
  } mirror_t;

  // one access beat
  typedef struct packed {
    logic              mode;
    logic [13:0]       address;
    logic [7:0]        write_data;
    logic              cart_hit;
    logic [7:0]        cart_data;
  } acc_in_t;

  // one result beat
  typedef struct packed {
    logic [7:0]        read_data;
    region_t           region;
  } acc_out_t;

endpackage

`default_nettype wire

// ----- design/ppu_vram_mirroring_map.sv -----
// ----------------------------------------------------------------------------
// ppu_vram_mirroring_map
// Video memory map: cartridge pass-through, local pattern store, mirrored
// name table store and aliased palette store.
// ----------------------------------------------------------------------------
//
//  channel   signals                         direction  handshake
//  --------  ------------------------------  ---------  --------------------------
//  access    start, busy, in_data            in         start & !busy
//  result    out_valid, out_data             out        one-cycle strobe
//  config    cfg_valid, cfg_ready, cfg_data  in         cfg_valid & cfg_ready
//
// An accepted access returns its result in the cycle after the accept; the
// stores are single-port synchronous memories and each access reads or writes
// once at the accept edge, so one access can be taken every clock.
// busy stays low; the result side never stalls, so nothing is held back.
// Reset clears the mirroring mode and the result strobe; store contents are
// undefined until written.
`default_nettype none

module ppu_vram_mirroring_map
  import pvmm_pkg::*;
#(
  parameter int unsigned PATTERN_BYTES = 8192,
  parameter int unsigned TABLE_BYTES   = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  // access channel
  input  wire logic     start,
  output logic          busy,
  input  wire acc_in_t  in_data,
  // result channel
  output logic          out_valid,
  output acc_out_t      out_data,
  // configuration channel
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [1:0] cfg_data
);

  localparam int unsigned PAT_AW = $clog2(PATTERN_BYTES);
  localparam int unsigned OFF_W  = $clog2(TABLE_BYTES);
  localparam int unsigned NT_AW  = OFF_W + 1;
  localparam int unsigned PAL_DEPTH = 2 ** PAL_AW;

  logic [7:0] pat_mem [PATTERN_BYTES];
  logic [7:0] nt_mem  [2 * TABLE_BYTES];
  logic [7:0] pal_mem [PAL_DEPTH];

  mirror_t     mirror_r;
  logic        out_valid_r;
  logic        is_write_r;
  region_t     region_r;
  logic [7:0]  cart_data_r;
  logic [7:0]  pat_rd_r;
  logic [7:0]  nt_rd_r;
  logic [7:0]  pal_rd_r;

  logic        accept;
  region_t     region_nxt;
  logic        nt_table;
  logic [NT_AW-1:0]  nt_idx;
  logic [PAL_AW-1:0] pal_idx;
  logic [PAT_AW-1:0] pat_idx;
  logic        wr_local;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // region decode
  always_comb begin
    if (in_data.cart_hit) begin
      region_nxt = REGION_CART;
    end else if (in_data.address < NT_BASE) begin
      region_nxt = REGION_PATTERN;
    end else if (in_data.address < PAL_BASE) begin
      region_nxt = REGION_NAMETABLE;
    end else begin
      region_nxt = REGION_PALETTE;
    end
  end

  // name table folding by mirroring mode
  always_comb begin
    case (mirror_r)
      MIRROR_HORIZ:     nt_table = in_data.address[11];
      MIRROR_VERT:      nt_table = in_data.address[10];
      MIRROR_SINGLE_LO: nt_table = 1'b0;
      MIRROR_SINGLE_HI: nt_table = 1'b1;
      default:          nt_table = 1'b0;
    endcase
  end

  assign nt_idx  = {nt_table, in_data.address[OFF_W-1:0]};
  assign pat_idx = in_data.address[PAT_AW-1:0];

  // palette folding, backdrop entries of sprite palettes alias the bg ones
  always_comb begin
    pal_idx = in_data.address[PAL_AW-1:0];
    if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
      pal_idx[4] = 1'b0;
    end
  end

  assign wr_local = accept && (in_data.mode == ACC_WRITE);

  // pattern store
  always_ff @(posedge clk) begin
    if (wr_local && region_nxt == REGION_PATTERN) begin
      pat_mem[pat_idx] <= in_data.write_data;
    end
    pat_rd_r <= pat_mem[pat_idx];
  end

  // name table store
  always_ff @(posedge clk) begin
    if (wr_local && region_nxt == REGION_NAMETABLE) begin
      nt_mem[nt_idx] <= in_data.write_data;
    end
    nt_rd_r <= nt_mem[nt_idx];
  end

  // palette store
  always_ff @(posedge clk) begin
    if (wr_local && region_nxt == REGION_PALETTE) begin
      pal_mem[pal_idx] <= in_data.write_data;
    end
    pal_rd_r <= pal_mem[pal_idx];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r    <= MIRROR_HORIZ;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mirror_r <= mirror_t'(cfg_data);
      end
      out_valid_r <= accept;
    end
  end

  // result side info carried next to the memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      is_write_r  <= in_data.mode;
      region_r    <= region_nxt;
      cart_data_r <= in_data.cart_data;
    end
  end

  // result select
  always_comb begin
    out_data.region = region_r;
    if (is_write_r == ACC_WRITE) begin
      out_data.read_data = 8'h00;
    end else begin
      case (region_r)
        REGION_CART:      out_data.read_data = cart_data_r;
        REGION_PATTERN:   out_data.read_data = pat_rd_r;
        REGION_NAMETABLE: out_data.read_data = nt_rd_r;
        REGION_PALETTE:   out_data.read_data = pal_rd_r;
        default:          out_data.read_data = 8'h00;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- design/pvmm_checker.sv -----
// ----------------------------------------------------------------------------
// pvmm_checker
// Port-level checks on the video memory map, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pvmm_checker
  import pvmm_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire acc_in_t  in_data,
  input wire logic     out_valid,
  input wire acc_out_t out_data
);

  // every accepted beat gives one result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start && !busy && rst_n) |-> out_valid)
    else $error("accepted access gave no result");

  // no result without an accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without an accepted access");

  // writes return zero data
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_data.mode) == ACC_WRITE) |-> out_data.read_data == 8'h00)
    else $error("write returned nonzero data");

  // claimed reads pass the cartridge byte through
  a_cart_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_data.cart_hit) && ($past(in_data.mode) == ACC_READ)
      |-> (out_data.region == REGION_CART)
          && (out_data.read_data == $past(in_data.cart_data)))
    else $error("cartridge read mismatch");

  // unclaimed low addresses land in the pattern store
  a_pattern_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(in_data.cart_hit) && ($past(in_data.address) < NT_BASE)
      |-> out_data.region == REGION_PATTERN)
    else $error("pattern access decoded to wrong region");

endmodule

bind ppu_vram_mirroring_map pvmm_checker u_pvmm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
